### design/htq_pkg.sv
// shared types, codes and constants for the heap timer queue
// no dependencies; used by heap_timer_queue
package htq_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned MAX_FIRE     = 32;
  localparam int unsigned DL_W         = 48;
  localparam int unsigned ID_W         = 31;
  localparam int unsigned TAG_W        = 32;
  localparam int unsigned TOL_W        = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd10;
  localparam logic [DL_W-1:0]  DL_MAX    = {DL_W{1'b1}};
  localparam logic [ID_W-1:0]  ID_MAX    = {ID_W{1'b1}};

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_ADDED     = 3'd0,
    K_CANCELLED = 3'd1,
    K_NOT_FOUND = 3'd2,
    K_FIRED     = 3'd3,
    K_NONE_DUE  = 3'd4,
    K_FULL      = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_CMP,
    ST_CN,
    ST_CN_CHK,
    ST_RM_LD,
    ST_DN,
    ST_DN_L,
    ST_DN_R,
    ST_TK,
    ST_TK_CHK,
    ST_FLUSH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [DL_W-1:0]  deadline;
    logic [ID_W-1:0]  ident;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // heap order: deadline first, lower id wins a tie
  function automatic logic earlier(entry_t a, entry_t b);
    logic r;
    if (a.deadline != b.deadline) r = a.deadline < b.deadline;
    else r = a.ident < b.ident;
    return r;
  endfunction

endpackage

### design/heap_timer_queue.sv
// heap_timer_queue: timer queue kept as a binary min-heap in one memory
// depends on htq_pkg
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid_i/tready_o       tuser operation, tdata fields
// m_axis    out  m_axis_tvalid_o/tready_i       tuser kind, tlast, tdata fields
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_data_i fire_tolerance
//
// one item at a time; heap memory has one read and one write port, with a
// registered read. add: a parent read and a compare per sift-up level. cancel:
// a read and an id check per scanned entry, then a sift of the last entry moved
// into the hole. tick: per fired timer a root read plus a sift-down, up to 32
// fires. no clearing pass at reset; only entries below the fill count are read.
// a stalled result register holds the sequencer where it needs to emit.
module heap_timer_queue #(
  parameter int unsigned CAPACITY = htq_pkg::CAPACITY_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // tdata: interval[31:0], cancel_target[62:32], user_tag[94:63], zero[95]
  input  logic [95:0]               s_axis_tdata_i,
  // tuser: operation[1:0]
  input  logic [1:0]                s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // tdata: timer_id[30:0], tag_out[62:31], zero[63]
  output logic [63:0]               m_axis_tdata_o,
  // tuser: kind[2:0]
  output logic [2:0]                m_axis_tuser_o,
  output logic                      m_axis_tlast_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [htq_pkg::TOL_W-1:0] cfg_data_i
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned NW = $clog2(htq_pkg::MAX_FIRE + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [NW-1:0] MAXF_C = NW'(htq_pkg::MAX_FIRE);

  // heap storage
  htq_pkg::entry_t mem [CAPACITY];
  htq_pkg::entry_t rd_q;
  logic            rd_en, wr_en;
  logic [IW-1:0]   rd_addr, wr_addr;
  htq_pkg::entry_t wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  htq_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [htq_pkg::ID_W-1:0] next_id_q, next_id_d;
  logic [htq_pkg::DL_W-1:0] now_q, now_d, thresh_q, thresh_d;
  logic [htq_pkg::TOL_W-1:0] tol_q;
  htq_pkg::op_e    op_q, op_d;
  htq_pkg::entry_t x_q, x_d, child_q, child_d;
  logic [IW-1:0]   k_q, k_d, cidx_q, cidx_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [htq_pkg::ID_W-1:0] target_q, target_d;
  logic            rm_q, rm_d;
  htq_pkg::kind_e  res_kind_q, res_kind_d;
  logic [htq_pkg::ID_W-1:0] res_id_q, res_id_d;
  logic [NW-1:0]   n_q, n_d;
  logic            pend_v_q, pend_v_d;
  logic [htq_pkg::ID_W-1:0] pend_id_q, pend_id_d;
  logic [htq_pkg::TAG_W-1:0] pend_tag_q, pend_tag_d;

  // result register
  logic            out_v_q;
  htq_pkg::kind_e  out_kind_q;
  logic [htq_pkg::ID_W-1:0] out_id_q;
  logic [htq_pkg::TAG_W-1:0] out_tag_q;
  logic            out_last_q;
  logic            slot_free, emit;
  htq_pkg::kind_e  e_kind;
  logic [htq_pkg::ID_W-1:0] e_id;
  logic [htq_pkg::TAG_W-1:0] e_tag;
  logic            e_last;

  assign slot_free       = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == htq_pkg::ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {1'b0, out_tag_q, out_id_q};

  // sequencer
  always_comb begin
    logic [htq_pkg::DL_W:0] sum;
    logic [IW:0]     l, r;
    logic [IW-1:0]   par;
    logic [CW-1:0]   cm1;
    htq_pkg::entry_t c;
    logic [IW-1:0]   ci;
    logic            eval;
    htq_pkg::state_e done_st;

    state_d    = state_q;
    count_d    = count_q;
    next_id_d  = next_id_q;
    now_d      = now_q;
    thresh_d   = thresh_q;
    op_d       = op_q;
    x_d        = x_q;
    child_d    = child_q;
    k_d        = k_q;
    cidx_d     = cidx_q;
    idx_d      = idx_q;
    target_d   = target_q;
    rm_d       = rm_q;
    res_kind_d = res_kind_q;
    res_id_d   = res_id_q;
    n_d        = n_q;
    pend_v_d   = pend_v_q;
    pend_id_d  = pend_id_q;
    pend_tag_d = pend_tag_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = k_q;
    wr_data    = x_q;
    emit       = 1'b0;
    e_kind     = htq_pkg::K_NONE_DUE;
    e_id       = '0;
    e_tag      = '0;
    e_last     = 1'b1;
    sum        = '0;
    l          = {k_q, 1'b1};
    r          = l + (IW+1)'(1);
    par        = IW'((k_q - IW'(1)) >> 1);
    cm1        = count_q - CW'(1);
    c          = rd_q;
    ci         = IW'(l);
    eval       = 1'b0;
    done_st    = (op_q == htq_pkg::OP_TICK) ? htq_pkg::ST_TK : htq_pkg::ST_EMIT;

    case (state_q)
      htq_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d     = htq_pkg::op_e'(s_axis_tuser_i);
          target_d = s_axis_tdata_i[62:32];
          case (htq_pkg::op_e'(s_axis_tuser_i))
            htq_pkg::OP_ADD: begin
              if (count_q >= CAP_C) begin
                res_kind_d = htq_pkg::K_FULL;
                res_id_d   = '0;
                state_d    = htq_pkg::ST_EMIT;
              end else begin
                sum = {1'b0, now_q} + (htq_pkg::DL_W+1)'(s_axis_tdata_i[31:0]);
                x_d.deadline = sum[htq_pkg::DL_W] ? htq_pkg::DL_MAX
                                                  : sum[htq_pkg::DL_W-1:0];
                x_d.ident  = next_id_q;
                x_d.tag    = s_axis_tdata_i[94:63];
                next_id_d  = (next_id_q == htq_pkg::ID_MAX) ? htq_pkg::ID_W'(1)
                                                           : next_id_q + htq_pkg::ID_W'(1);
                res_kind_d = htq_pkg::K_ADDED;
                res_id_d   = next_id_q;
                k_d        = IW'(count_q);
                count_d    = count_q + CW'(1);
                rm_d       = 1'b0;
                state_d    = htq_pkg::ST_UP;
              end
            end
            htq_pkg::OP_CANCEL: begin
              idx_d   = '0;
              state_d = htq_pkg::ST_CN;
            end
            htq_pkg::OP_TICK: begin
              now_d = (now_q == htq_pkg::DL_MAX) ? now_q : now_q + htq_pkg::DL_W'(1);
              sum   = {1'b0, now_d} + (htq_pkg::DL_W+1)'(tol_q);
              thresh_d = sum[htq_pkg::DL_W] ? htq_pkg::DL_MAX : sum[htq_pkg::DL_W-1:0];
              n_d      = '0;
              pend_v_d = 1'b0;
              state_d  = htq_pkg::ST_TK;
            end
            default: state_d = htq_pkg::ST_IDLE;
          endcase
        end
      end
      // sift-up: hole at k, carried item in x
      htq_pkg::ST_UP: begin
        if (k_q == '0) begin
          wr_en   = 1'b1;
          state_d = done_st;
        end else begin
          rd_en   = 1'b1;
          rd_addr = par;
          state_d = htq_pkg::ST_UP_CMP;
        end
      end
      htq_pkg::ST_UP_CMP: begin
        rm_d = 1'b0;
        if (htq_pkg::earlier(x_q, rd_q)) begin
          wr_en   = 1'b1;
          wr_data = rd_q;
          k_d     = par;
          state_d = htq_pkg::ST_UP;
        end else if (rm_q) begin
          state_d = htq_pkg::ST_DN;
        end else begin
          wr_en   = 1'b1;
          state_d = done_st;
        end
      end
      // linear id search
      htq_pkg::ST_CN: begin
        if (idx_q == count_q) begin
          res_kind_d = htq_pkg::K_NOT_FOUND;
          res_id_d   = '0;
          state_d    = htq_pkg::ST_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IW'(idx_q);
          state_d = htq_pkg::ST_CN_CHK;
        end
      end
      htq_pkg::ST_CN_CHK: begin
        if (rd_q.ident == target_q) begin
          res_kind_d = htq_pkg::K_CANCELLED;
          res_id_d   = target_q;
          count_d    = cm1;
          k_d        = IW'(idx_q);
          if (idx_q == cm1) begin
            state_d = htq_pkg::ST_EMIT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = IW'(cm1);
            state_d = htq_pkg::ST_RM_LD;
          end
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = htq_pkg::ST_CN;
        end
      end
      // last entry loaded into the hole; try up first, else down
      htq_pkg::ST_RM_LD: begin
        x_d = rd_q;
        if (k_q == '0) begin
          state_d = htq_pkg::ST_DN;
        end else begin
          rm_d    = 1'b1;
          rd_en   = 1'b1;
          rd_addr = par;
          state_d = htq_pkg::ST_UP_CMP;
        end
      end
      // sift-down: read left, then right child
      htq_pkg::ST_DN: begin
        if (l >= (IW+1)'(count_q)) begin
          wr_en   = 1'b1;
          state_d = done_st;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IW'(l);
          state_d = htq_pkg::ST_DN_L;
        end
      end
      htq_pkg::ST_DN_L: begin
        child_d = rd_q;
        cidx_d  = IW'(l);
        if (r < (IW+1)'(count_q)) begin
          rd_en   = 1'b1;
          rd_addr = IW'(r);
          state_d = htq_pkg::ST_DN_R;
        end else begin
          c    = rd_q;
          ci   = IW'(l);
          eval = 1'b1;
        end
      end
      htq_pkg::ST_DN_R: begin
        if (htq_pkg::earlier(rd_q, child_q)) begin
          c  = rd_q;
          ci = cidx_q + IW'(1);
        end else begin
          c  = child_q;
          ci = cidx_q;
        end
        eval = 1'b1;
      end
      // tick: fire from the root while due, up to the fire limit
      htq_pkg::ST_TK: begin
        if (count_q == '0 || n_q == MAXF_C) begin
          state_d = htq_pkg::ST_FLUSH;
        end else begin
          rd_en   = 1'b1;
          rd_addr = '0;
          state_d = htq_pkg::ST_TK_CHK;
        end
      end
      htq_pkg::ST_TK_CHK: begin
        if (rd_q.deadline <= thresh_q) begin
          if (!pend_v_q || slot_free) begin
            emit       = pend_v_q;
            e_kind     = htq_pkg::K_FIRED;
            e_id       = pend_id_q;
            e_tag      = pend_tag_q;
            e_last     = 1'b0;
            pend_v_d   = 1'b1;
            pend_id_d  = rd_q.ident;
            pend_tag_d = rd_q.tag;
            n_d        = n_q + NW'(1);
            count_d    = cm1;
            k_d        = '0;
            if (cm1 == '0) begin
              state_d = htq_pkg::ST_TK;
            end else begin
              rd_en   = 1'b1;
              rd_addr = IW'(cm1);
              state_d = htq_pkg::ST_RM_LD;
            end
          end
        end else begin
          state_d = htq_pkg::ST_FLUSH;
        end
      end
      htq_pkg::ST_FLUSH: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_last  = 1'b1;
          e_kind  = pend_v_q ? htq_pkg::K_FIRED : htq_pkg::K_NONE_DUE;
          e_id    = pend_v_q ? pend_id_q : '0;
          e_tag   = pend_v_q ? pend_tag_q : '0;
          state_d = htq_pkg::ST_IDLE;
        end
      end
      htq_pkg::ST_EMIT: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_kind  = res_kind_q;
          e_id    = res_id_q;
          e_tag   = '0;
          e_last  = 1'b1;
          state_d = htq_pkg::ST_IDLE;
        end
      end
      default: state_d = htq_pkg::ST_IDLE;
    endcase

    // sift-down decision on the smaller child
    if (eval) begin
      wr_en = 1'b1;
      if (htq_pkg::earlier(c, x_q)) begin
        wr_data = c;
        k_d     = ci;
        state_d = htq_pkg::ST_DN;
      end else begin
        state_d = done_st;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= htq_pkg::ST_IDLE;
      count_q   <= '0;
      next_id_q <= htq_pkg::ID_W'(1);
      now_q     <= '0;
      tol_q     <= htq_pkg::TOL_RESET;
      out_v_q   <= 1'b0;
      pend_v_q  <= 1'b0;
      rm_q      <= 1'b0;
      n_q       <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      now_q     <= now_d;
      pend_v_q  <= pend_v_d;
      rm_q      <= rm_d;
      n_q       <= n_d;
      if (cfg_valid_i) tol_q <= cfg_data_i;
      if (emit) out_v_q <= 1'b1;
      else if (m_axis_tready_i) out_v_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    thresh_q   <= thresh_d;
    op_q       <= op_d;
    x_q        <= x_d;
    child_q    <= child_d;
    k_q        <= k_d;
    cidx_q     <= cidx_d;
    idx_q      <= idx_d;
    target_q   <= target_d;
    res_kind_q <= res_kind_d;
    res_id_q   <= res_id_d;
    pend_id_q  <= pend_id_d;
    pend_tag_q <= pend_tag_d;
    if (emit) begin
      out_kind_q <= e_kind;
      out_id_q   <= e_id;
      out_tag_q  <= e_tag;
      out_last_q <= e_last;
    end
  end

`ifndef NO_ASSERTIONS
  // fill count stays within the heap
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C) else $error("heap count beyond capacity");

  // fill count moves by at most one entry per cycle
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (count_q == $past(count_q) || count_q == $past(count_q) + CW'(1) ||
         count_q == $past(count_q) - CW'(1)))
    else $error("heap count jumped");

  // no more fires per tick than the limit
  a_fire_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= MAXF_C) else $error("too many fires in one tick");

  // a new result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> slot_free) else $error("result register overwritten");
`endif

endmodule

### test/tb.sv
// self-checking testbench for heap_timer_queue: directed table, then random phases
// depends on htq_pkg and heap_timer_queue; predicts every result with its own heap model
`timescale 1ns / 100ps

module tb;
  import htq_pkg::*;

  localparam int HEAP_DEPTH = 32;
  localparam int DRAIN_WAIT = 300;
  localparam int STALL_LIMIT = 6000;

  typedef struct packed {
    kind_e           kind;
    logic [ID_W-1:0]  id;
    logic [TAG_W-1:0] tag;
    logic             last;
  } timer_event_t;

  typedef struct {
    op_e              op;
    logic [31:0]      interval;
    logic [ID_W-1:0]  target;
    logic [TAG_W-1:0] tag;
    bit               typed;
    kind_e            kind;
    logic [ID_W-1:0]  id;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [95:0] s_data = '0;
  logic [1:0] s_user = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [63:0] m_data;
  logic [2:0] m_user;
  logic m_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TOL_W-1:0] cfg_data = '0;

  // timer model state
  logic [DL_W-1:0]  pr_deadline[HEAP_DEPTH];
  logic [ID_W-1:0]  pr_ident[HEAP_DEPTH];
  logic [TAG_W-1:0] pr_tag[HEAP_DEPTH];
  int               pr_count;
  logic [ID_W-1:0]  pr_next_id;
  logic [DL_W-1:0]  pr_now;
  logic [TOL_W-1:0] pr_tolerance;

  timer_event_t pending_events[$];
  int  errors = 0;
  int  requests_sent = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  held = 1'b0;

  heap_timer_queue u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  // clock, period 12 ns
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // heap order helpers
  function automatic bit slot_before(int a, int b);
    if (pr_deadline[a] != pr_deadline[b]) return pr_deadline[a] < pr_deadline[b];
    return pr_ident[a] < pr_ident[b];
  endfunction

  function automatic void swap_slot(int a, int b);
    logic [DL_W-1:0] d;
    logic [ID_W-1:0] i;
    logic [TAG_W-1:0] t;
    d = pr_deadline[a]; i = pr_ident[a]; t = pr_tag[a];
    pr_deadline[a] = pr_deadline[b]; pr_ident[a] = pr_ident[b]; pr_tag[a] = pr_tag[b];
    pr_deadline[b] = d; pr_ident[b] = i; pr_tag[b] = t;
  endfunction

  function automatic void bubble_up(int k);
    int p;
    while (k > 0) begin
      p = (k - 1) / 2;
      if (!slot_before(k, p)) break;
      swap_slot(k, p);
      k = p;
    end
  endfunction

  function automatic void bubble_down(int k);
    int l;
    int m;
    forever begin
      l = 2 * k + 1;
      m = k;
      if (l < pr_count && slot_before(l, m)) m = l;
      if (l + 1 < pr_count && slot_before(l + 1, m)) m = l + 1;
      if (m == k) break;
      swap_slot(k, m);
      k = m;
    end
  endfunction

  function automatic void drop_slot(int k);
    pr_count--;
    if (k == pr_count) return;
    pr_deadline[k] = pr_deadline[pr_count];
    pr_ident[k] = pr_ident[pr_count];
    pr_tag[k] = pr_tag[pr_count];
    bubble_up(k);
    bubble_down(k);
  endfunction

  function automatic void push_event(kind_e k, logic [ID_W-1:0] id, logic [TAG_W-1:0] tag,
                                     logic last);
    timer_event_t e;
    e.kind = k; e.id = id; e.tag = tag; e.last = last;
    pending_events = {pending_events, e};
  endfunction

  // advance the timer model by one request and queue the results it causes
  function automatic void predict_timers(op_e op, logic [31:0] interval,
                                         logic [ID_W-1:0] target, logic [TAG_W-1:0] tag);
    logic [DL_W:0] sum;
    logic [DL_W:0] thresh;
    int fired;
    bit hit;
    fired = 0;
    hit = 1'b0;
    case (op)
      OP_ADD: begin
        if (pr_count >= HEAP_DEPTH) begin
          push_event(K_FULL, '0, '0, 1'b1);
        end else begin
          sum = {1'b0, pr_now} + (DL_W+1)'(interval);
          if (sum > {1'b0, DL_MAX}) sum = {1'b0, DL_MAX};
          pr_deadline[pr_count] = sum[DL_W-1:0];
          pr_ident[pr_count] = pr_next_id;
          pr_tag[pr_count] = tag;
          pr_count++;
          bubble_up(pr_count - 1);
          push_event(K_ADDED, pr_next_id, '0, 1'b1);
          pr_next_id = (pr_next_id == ID_MAX) ? ID_W'(1) : pr_next_id + ID_W'(1);
        end
      end
      OP_CANCEL: begin
        for (int k = 0; k < pr_count && !hit; k++) begin
          if (pr_ident[k] == target) begin
            drop_slot(k);
            hit = 1'b1;
          end
        end
        if (hit) push_event(K_CANCELLED, target, '0, 1'b1);
        else push_event(K_NOT_FOUND, '0, '0, 1'b1);
      end
      OP_TICK: begin
        if (pr_now != DL_MAX) pr_now++;
        thresh = {1'b0, pr_now} + (DL_W+1)'(pr_tolerance);
        if (thresh > {1'b0, DL_MAX}) thresh = {1'b0, DL_MAX};
        while (pr_count > 0 && fired < MAX_FIRE && pr_deadline[0] <= thresh) begin
          push_event(K_FIRED, pr_ident[0], pr_tag[0], 1'b0);
          fired++;
          drop_slot(0);
        end
        if (fired == 0) push_event(K_NONE_DUE, '0, '0, 1'b1);
        else pending_events[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // offer one request and hold it until the block takes it
  task automatic send_request(op_e op, logic [31:0] interval, logic [ID_W-1:0] target,
                              logic [TAG_W-1:0] tag);
    s_valid <= 1'b1;
    s_user <= op;
    s_data <= {1'b0, tag, target, interval};
    forever begin
      @(negedge clk_i);
      if (s_ready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    predict_timers(op, interval, target, tag);
    requests_sent++;
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // wait for every expected result, then let any trailing work settle
  task automatic drain();
    s_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    forever begin
      @(negedge clk_i);
      if (cfg_ready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    cfg_valid <= 1'b0;
    pr_tolerance = value;
  endtask

  // result check, sampled mid-cycle where outputs are stable
  always @(negedge clk_i) begin
    timer_event_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result kind=%0d id=%0d", m_user, m_data[30:0]);
        errors++;
      end else begin
        want = pending_events.pop_front();
        if (m_user != want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_user);
          errors++;
        end
        if (m_data[30:0] != want.id) begin
          $error("timer_id: expected %0d, got %0d", want.id, m_data[30:0]);
          errors++;
        end
        if (m_data[62:31] != want.tag) begin
          $error("tag_out: expected %h, got %h", want.tag, m_data[62:31]);
          errors++;
        end
        if (m_last != want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(negedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!quiet && !held && requests_sent >= 100) begin
        held = 1'b1;
        m_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  // stimulus
  initial begin
    table_row_t rows[$];
    logic [TOL_W-1:0] tol_plan[5];
    op_e op;
    logic [31:0] interval;
    logic [ID_W-1:0] target;
    int pick;
    int count;

    pr_count = 0;
    pr_next_id = ID_W'(1);
    pr_now = '0;
    pr_tolerance = TOL_RESET;

    // directed: empty queue, extremes, cancel hit and miss, tie order, unused code
    rows = '{
      '{OP_TICK,   32'd0,          31'd0,          32'd0,          1, K_NONE_DUE,  31'd0},
      '{OP_CANCEL, 32'd0,          31'd1,          32'd0,          1, K_NOT_FOUND, 31'd0},
      '{OP_CANCEL, 32'hFFFFFFFF,   31'h7FFFFFFF,   32'hFFFFFFFF,   1, K_NOT_FOUND, 31'd0},
      '{OP_ADD,    32'd0,          31'd0,          32'hFFFFFFFF,   1, K_ADDED,     31'd1},
      '{OP_ADD,    32'hFFFFFFFF,   31'h7FFFFFFF,   32'd0,          1, K_ADDED,     31'd2},
      '{OP_ADD,    32'd5,          31'd0,          32'hA5A5A5A5,   1, K_ADDED,     31'd3},
      '{OP_ADD,    32'd5,          31'd0,          32'h5A5A5A5A,   1, K_ADDED,     31'd4},
      '{OP_ADD,    32'd3,          31'd0,          32'h12345678,   1, K_ADDED,     31'd5},
      '{OP_CANCEL, 32'd0,          31'd2,          32'd0,          1, K_CANCELLED, 31'd2},
      '{OP_TICK,   32'd0,          31'd0,          32'd0,          0, K_FIRED,     31'd0},
      '{OP_NONE,   32'hFFFFFFFF,   31'h7FFFFFFF,   32'hFFFFFFFF,   0, K_FIRED,     31'd0},
      '{OP_TICK,   32'd0,          31'd0,          32'd0,          1, K_NONE_DUE,  31'd0},
      '{OP_ADD,    32'd20,         31'd0,          32'hDEADBEEF,   1, K_ADDED,     31'd6},
      '{OP_CANCEL, 32'd0,          31'd3,          32'd0,          1, K_NOT_FOUND, 31'd0},
      '{OP_CANCEL, 32'd0,          31'd6,          32'd0,          1, K_CANCELLED, 31'd6}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      send_request(rows[r].op, rows[r].interval, rows[r].target, rows[r].tag);
      if (rows[r].typed) begin
        pending_events.delete(pending_events.size() - 1);
        push_event(rows[r].kind, rows[r].id, '0, 1'b1);
      end
      sender_gap();
    end
    drain();

    // random phases, each under its own tolerance
    tol_plan = '{16'd0, 16'hFFFF, 16'($urandom), 16'd1, TOL_RESET};
    for (int ph = 0; ph < 5; ph++) begin
      write_tolerance(tol_plan[ph]);
      quiet = (ph == 4);
      count = 0;
      while (count < 65) begin
        pick = $urandom_range(0, 99);
        // phase one opens with a run of adds to fill the heap past capacity
        if (ph == 1 && count < 36) pick = 0;
        if (pick < 45) op = OP_ADD;
        else if (pick < 65) op = OP_CANCEL;
        else if (pick < 95) op = OP_TICK;
        else op = OP_NONE;
        interval = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 60);
        if ($urandom_range(0, 4) == 0)
          target = 31'($urandom);
        else if (pr_next_id > 40)
          target = pr_next_id - 31'($urandom_range(1, 40));
        else
          target = 31'($urandom_range(1, 40));
        send_request(op, interval, target, $urandom);
        if (op != OP_NONE) count++;
        sender_gap();
      end
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
design/htq_pkg.sv
design/heap_timer_queue.sv
test/tb.sv
